### rtl/core/kti_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the knot
// table interpolator. Used by every module in rtl/core; depends on nothing.
package kti_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int ADDR_W    = $clog2(MAX_KNOTS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int WIDE_W    = DATA_W + FRAC_W;

  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOT_INC = 2'd2;

  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  localparam logic [1:0] SGN_ZERO = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;

  typedef logic signed [DATA_W-1:0] num_t;

  // Request bundle from the sequencer to the knot/tangent memories.
  typedef struct packed {
    logic              knot_we;
    logic              tan_we;
    logic [ADDR_W-1:0] waddr;
    num_t              wtime;
    num_t              wvalue;
    num_t              wtan;
    logic [ADDR_W-1:0] raddr;
  } tbl_req_t;

  function automatic num_t sat_add(input num_t a, input num_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? VMIN : VMAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic num_t sat_sub(input num_t a, input num_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? VMIN : VMAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic num_t twice(input num_t a);
    return sat_add(a, a);
  endfunction

  function automatic num_t thrice(input num_t a);
    return sat_add(sat_add(a, a), a);
  endfunction

  function automatic num_t sat_abs(input num_t a);
    return a[DATA_W-1] ? sat_sub('0, a) : a;
  endfunction

  function automatic logic [1:0] sgn(input num_t a);
    if (a == '0) return SGN_ZERO;
    return a[DATA_W-1] ? SGN_NEG : SGN_POS;
  endfunction

  function automatic logic [DATA_W-1:0] mag(input num_t a);
    return a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
  endfunction

  // Signed result from an unsigned magnitude, saturated to the number range.
  function automatic num_t from_mag(input logic [WIDE_W-1:0] m, input logic neg);
    logic [DATA_W-1:0] lo;
    lo = m[DATA_W-1:0];
    if (neg) begin
      if (m > WIDE_W'({1'b1, {(DATA_W-1){1'b0}}})) return VMIN;
      return ~lo + DATA_W'(1);
    end
    if (m > WIDE_W'(VMAX)) return VMAX;
    return lo;
  endfunction

endpackage

### rtl/core/kti_table.sv
// Knot time, knot value and tangent memories, one write and one read port,
// read data registered. Depends on kti_pkg.
module kti_table (
  input  logic              clk,
  input  kti_pkg::tbl_req_t req,
  output kti_pkg::num_t     rd_time,
  output kti_pkg::num_t     rd_value,
  output kti_pkg::num_t     rd_tan
);

  kti_pkg::num_t time_mem [kti_pkg::MAX_KNOTS];
  kti_pkg::num_t value_mem[kti_pkg::MAX_KNOTS];
  kti_pkg::num_t tan_mem  [kti_pkg::MAX_KNOTS];

  always_ff @(posedge clk) begin
    if (req.knot_we) begin
      time_mem[req.waddr]  <= req.wtime;
      value_mem[req.waddr] <= req.wvalue;
    end
    if (req.tan_we) begin
      tan_mem[req.waddr] <= req.wtan;
    end
    rd_time  <= time_mem[req.raddr];
    rd_value <= value_mem[req.raddr];
    rd_tan   <= tan_mem[req.raddr];
  end

endmodule

### rtl/core/kti_mul.sv
// Two-stage saturating fixed-point multiplier (magnitudes, then product).
// Depends on kti_pkg.
module kti_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  kti_pkg::num_t a,
  input  kti_pkg::num_t b,
  output logic          done,
  output kti_pkg::num_t q
);

  logic [kti_pkg::DATA_W-1:0]   ma_r, mb_r;
  logic                         neg1_r, neg2_r, v1_r, v2_r;
  logic [2*kti_pkg::DATA_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    ma_r   <= kti_pkg::mag(a);
    mb_r   <= kti_pkg::mag(b);
    neg1_r <= a[kti_pkg::DATA_W-1] ^ b[kti_pkg::DATA_W-1];
    if (v1_r) begin
      prod_r <= ma_r * mb_r;
      neg2_r <= neg1_r;
    end
  end

  assign done = v2_r;
  assign q    = kti_pkg::from_mag(
      prod_r[2*kti_pkg::DATA_W-1:kti_pkg::FRAC_W], neg2_r);

endmodule

### rtl/core/kti_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// Depends on kti_pkg.
module kti_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  kti_pkg::num_t a,
  input  kti_pkg::num_t b,
  output logic          done,
  output kti_pkg::num_t q
);

  localparam int CW = $clog2(kti_pkg::WIDE_W);

  logic                         busy_r, done_r, neg_r;
  logic [CW-1:0]                cnt_r;
  logic [kti_pkg::DATA_W-1:0]   rem_r, d_r;
  logic [kti_pkg::WIDE_W-1:0]   nq_r;
  kti_pkg::num_t                q_r;

  logic [kti_pkg::DATA_W:0]     rem_sh, rem_sub;
  logic                         ge;
  logic [kti_pkg::WIDE_W-1:0]   nq_new;

  always_comb begin
    rem_sh  = {rem_r, nq_r[kti_pkg::WIDE_W-1]};
    rem_sub = rem_sh - {1'b0, d_r};
    ge      = rem_sh >= {1'b0, d_r};
    nq_new  = {nq_r[kti_pkg::WIDE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (b == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      if (a == '0)      q_r <= '0;
      else if (a[kti_pkg::DATA_W-1]) q_r <= kti_pkg::VMIN;
      else              q_r <= kti_pkg::VMAX;
      d_r   <= kti_pkg::mag(b);
      neg_r <= a[kti_pkg::DATA_W-1] ^ b[kti_pkg::DATA_W-1];
      nq_r  <= {kti_pkg::mag(a), {kti_pkg::FRAC_W{1'b0}}};
      rem_r <= '0;
      cnt_r <= CW'(kti_pkg::WIDE_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[kti_pkg::DATA_W-1:0] : rem_sh[kti_pkg::DATA_W-1:0];
      nq_r  <= nq_new;
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == '0) q_r <= kti_pkg::from_mag(nq_new, neg_r);
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

### rtl/core/knot_table_interpolator_core.sv
// Knot table interpolator: sequencer around the knot/tangent memories, a
// shared multiplier and a shared divider. Depends on kti_pkg, kti_table,
// kti_mul and kti_div.
//
// Input beats carry an operation in in_tuser (clear, append, evaluate) and
// knot time, knot value and query time in in_tdata. Every input beat gives
// exactly one output beat: result value and append status in out_tdata.
// Mode (step, linear, monotone cubic) is written on cfg_wr_en/cfg_wr_data.
// One item is worked at a time; in_tready is high while the sequencer idles,
// also while an earlier result still waits in the output register.
// Evaluate runs the end checks and a binary search (one memory read per
// probe), then one serial divide and one multiply for linear, or one
// divide and eight multiplies for cubic. The first cubic evaluation inside
// the knot range after the table changes first rebuilds all tangents,
// bound by the serial divider (a secant divide per interval, up to three
// more per interior knot). Reset empties the table, marks tangents stale
// and selects step mode; the memories are not cleared. When the output
// register is full and out_tready is low, a finished result waits in the
// sequencer and no new beat is taken until it moves to the output.
module knot_table_interpolator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // knot_time, knot_value, query_time
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value, status, zero fill
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  localparam int AW = kti_pkg::ADDR_W;
  localparam int CW = kti_pkg::CNT_W;

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_FINISH = 6'd1;
  localparam logic [5:0] S_WDIV   = 6'd2;
  localparam logic [5:0] S_WMUL   = 6'd3;
  localparam logic [5:0] E_FIRST  = 6'd4;
  localparam logic [5:0] E_LAST   = 6'd5;
  localparam logic [5:0] E_SRCH   = 6'd6;
  localparam logic [5:0] E_SCMP   = 6'd7;
  localparam logic [5:0] E_PICK   = 6'd8;
  localparam logic [5:0] E_STEP   = 6'd9;
  localparam logic [5:0] E_RA     = 6'd10;
  localparam logic [5:0] E_RB     = 6'd11;
  localparam logic [5:0] E_D2     = 6'd12;
  localparam logic [5:0] E_L3     = 6'd13;
  localparam logic [5:0] E_C3     = 6'd14;
  localparam logic [5:0] E_C4     = 6'd15;
  localparam logic [5:0] E_C5     = 6'd16;
  localparam logic [5:0] E_C6     = 6'd17;
  localparam logic [5:0] E_C7     = 6'd18;
  localparam logic [5:0] E_C8     = 6'd19;
  localparam logic [5:0] E_C9     = 6'd20;
  localparam logic [5:0] E_C10    = 6'd21;
  localparam logic [5:0] R_INIT   = 6'd22;
  localparam logic [5:0] R_RD0    = 6'd23;
  localparam logic [5:0] R_RD1    = 6'd24;
  localparam logic [5:0] R_S2     = 6'd25;
  localparam logic [5:0] R_I1     = 6'd26;
  localparam logic [5:0] R_I2     = 6'd27;
  localparam logic [5:0] R_I3     = 6'd28;
  localparam logic [5:0] R_I4     = 6'd29;
  localparam logic [5:0] R_NEXT   = 6'd30;
  localparam logic [5:0] R_END    = 6'd31;
  localparam logic [5:0] R_W0     = 6'd32;
  localparam logic [5:0] R_W1     = 6'd33;
  localparam logic [5:0] R_T1     = 6'd34;
  localparam logic [5:0] R_T2     = 6'd35;
  localparam logic [5:0] R_T3     = 6'd36;
  localparam logic [5:0] R_T4     = 6'd37;
  localparam logic [5:0] R_DONE   = 6'd38;

  logic [5:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0] mode_r;
  logic [CW-1:0] count_r, count_nxt;
  logic current_r, current_nxt;
  logic eb_r, eb_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, k_r, k_nxt;
  logic [1:0] stat_r, stat_nxt, out_stat_r, out_stat_nxt;
  logic out_valid_r, out_valid_nxt;

  kti_pkg::num_t last_t_r, last_t_nxt, tau_r, tau_nxt, res_r, res_nxt;
  kti_pkg::num_t out_res_r, out_res_nxt;
  kti_pkg::num_t x0_r, x0_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  kti_pkg::num_t m0_r, m0_nxt, m1_r, m1_nxt, h_r, h_nxt;
  kti_pkg::num_t t_r, t_nxt, t2_r, t2_nxt, t3_r, t3_nxt, acc_r, acc_nxt;
  kti_pkg::num_t tmp_r, tmp_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  kti_pkg::num_t ha_r, ha_nxt, sa_r, sa_nxt, hb_r, hb_nxt, sb_r, sb_nxt;
  kti_pkg::num_t h0_r, h0_nxt, s0_r, s0_nxt, h1_r, h1_nxt, s1_r, s1_nxt;

  kti_pkg::tbl_req_t req;
  kti_pkg::num_t rd_time, rd_value, rd_tan;
  logic mul_start, mul_done, div_start, div_done;
  kti_pkg::num_t mul_a, mul_b, mul_q, div_a, div_b, div_q;

  kti_pkg::num_t in_time, in_value, in_query;
  kti_pkg::num_t eh0, eh1, es0, es1, den, dd, ww1, ww2;
  logic [AW-1:0] last_idx, diff;

  kti_table u_table (
    .clk      (clk),
    .req      (req),
    .rd_time  (rd_time),
    .rd_value (rd_value),
    .rd_tan   (rd_tan)
  );

  kti_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .q     (mul_q)
  );

  kti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  assign in_time  = in_tdata[31:0];
  assign in_value = in_tdata[63:32];
  assign in_query = in_tdata[95:64];
  assign last_idx = AW'(count_r - CW'(1));
  assign diff     = hi_r - lo_r;

  // End tangent operands: first end, then last end.
  assign eh0 = eb_r ? ha_r : h0_r;
  assign eh1 = eb_r ? hb_r : h1_r;
  assign es0 = eb_r ? sa_r : s0_r;
  assign es1 = eb_r ? sb_r : s1_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_stat_r, out_res_r};

  always_comb begin
    state_nxt = state_r;    ret_nxt = ret_r;       count_nxt = count_r;
    current_nxt = current_r; eb_nxt = eb_r;        lo_nxt = lo_r;
    hi_nxt = hi_r;          mid_nxt = mid_r;       k_nxt = k_r;
    stat_nxt = stat_r;      last_t_nxt = last_t_r; tau_nxt = tau_r;
    res_nxt = res_r;        x0_nxt = x0_r;         y0_nxt = y0_r;
    y1_nxt = y1_r;          m0_nxt = m0_r;         m1_nxt = m1_r;
    h_nxt = h_r;            t_nxt = t_r;           t2_nxt = t2_r;
    t3_nxt = t3_r;          acc_nxt = acc_r;       tmp_nxt = tmp_r;
    w1_nxt = w1_r;          w2_nxt = w2_r;         ha_nxt = ha_r;
    sa_nxt = sa_r;          hb_nxt = hb_r;         sb_nxt = sb_r;
    h0_nxt = h0_r;          s0_nxt = s0_r;         h1_nxt = h1_r;
    s1_nxt = s1_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_stat_nxt  = out_stat_r;
    req        = '0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    den        = kti_pkg::sat_add(tmp_r, div_q);
    dd         = div_q;
    ww1        = kti_pkg::sat_add(kti_pkg::twice(ha_r), hb_r);
    ww2        = kti_pkg::sat_add(ha_r, kti_pkg::twice(hb_r));

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt   = '0;
          stat_nxt  = kti_pkg::ST_OK;
          tau_nxt   = in_query;
          state_nxt = S_FINISH;
          case (in_tuser)
            kti_pkg::OP_CLEAR: begin
              count_nxt   = '0;
              current_nxt = 1'b0;
            end
            kti_pkg::OP_APPEND: begin
              if (count_r[CW-1]) begin
                stat_nxt = kti_pkg::ST_FULL;
              end else if (count_r != '0 && in_time <= last_t_r) begin
                stat_nxt = kti_pkg::ST_NOT_INC;
              end else begin
                req.knot_we = 1'b1;
                req.waddr   = count_r[AW-1:0];
                req.wtime   = in_time;
                req.wvalue  = in_value;
                last_t_nxt  = in_time;
                count_nxt   = count_r + CW'(1);
                current_nxt = 1'b0;
              end
            end
            kti_pkg::OP_EVAL: begin
              req.raddr = '0;
              if (count_r != '0) state_nxt = E_FIRST;
            end
            default: ;
          endcase
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      S_WDIV: if (div_done) state_nxt = ret_r;
      S_WMUL: if (mul_done) state_nxt = ret_r;
      E_FIRST: begin
        if (count_r == CW'(1) || tau_r <= rd_time) begin
          res_nxt   = rd_value;
          state_nxt = S_FINISH;
        end else begin
          req.raddr = last_idx;
          state_nxt = E_LAST;
        end
      end
      E_LAST: begin
        if (tau_r >= rd_time) begin
          res_nxt   = rd_value;
          state_nxt = S_FINISH;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last_idx;
          state_nxt = E_SRCH;
        end
      end
      E_SRCH: begin
        if (diff > AW'(1)) begin
          mid_nxt   = lo_r + (diff >> 1);
          req.raddr = lo_r + (diff >> 1);
          state_nxt = E_SCMP;
        end else begin
          state_nxt = E_PICK;
        end
      end
      E_SCMP: begin
        if (rd_time <= tau_r) lo_nxt = mid_r;
        else                  hi_nxt = mid_r;
        state_nxt = E_SRCH;
      end
      E_PICK: begin
        req.raddr = lo_r;
        case (mode_r)
          kti_pkg::MODE_STEP:   state_nxt = E_STEP;
          kti_pkg::MODE_LINEAR: state_nxt = E_RA;
          kti_pkg::MODE_CUBIC:  state_nxt = current_r ? E_RA : R_INIT;
          default: begin
            res_nxt   = '0;
            state_nxt = S_FINISH;
          end
        endcase
      end
      E_STEP: begin
        res_nxt   = rd_value;
        state_nxt = S_FINISH;
      end
      E_RA: begin
        x0_nxt    = rd_time;
        y0_nxt    = rd_value;
        m0_nxt    = rd_tan;
        req.raddr = lo_r + AW'(1);
        state_nxt = E_RB;
      end
      E_RB: begin
        y1_nxt    = rd_value;
        m1_nxt    = rd_tan;
        h_nxt     = kti_pkg::sat_sub(rd_time, x0_r);
        div_start = 1'b1;
        div_a     = kti_pkg::sat_sub(tau_r, x0_r);
        div_b     = kti_pkg::sat_sub(rd_time, x0_r);
        ret_nxt   = E_D2;
        state_nxt = S_WDIV;
      end
      E_D2: begin
        mul_start = 1'b1;
        state_nxt = S_WMUL;
        if (mode_r == kti_pkg::MODE_LINEAR) begin
          mul_a   = kti_pkg::sat_sub(y1_r, y0_r);
          mul_b   = div_q;
          ret_nxt = E_L3;
        end else begin
          t_nxt   = div_q;
          mul_a   = div_q;
          mul_b   = div_q;
          ret_nxt = E_C3;
        end
      end
      E_L3: begin
        res_nxt   = kti_pkg::sat_add(y0_r, mul_q);
        state_nxt = S_FINISH;
      end
      E_C3: begin
        t2_nxt    = mul_q;
        mul_start = 1'b1;
        mul_a     = mul_q;
        mul_b     = t_r;
        ret_nxt   = E_C4;
        state_nxt = S_WMUL;
      end
      E_C4: begin
        t3_nxt    = mul_q;
        mul_start = 1'b1;
        mul_a     = kti_pkg::sat_add(kti_pkg::sat_sub(kti_pkg::twice(mul_q),
                                     kti_pkg::thrice(t2_r)), kti_pkg::ONE);
        mul_b     = y0_r;
        ret_nxt   = E_C5;
        state_nxt = S_WMUL;
      end
      E_C5: begin
        acc_nxt   = mul_q;
        mul_start = 1'b1;
        mul_a     = kti_pkg::sat_add(kti_pkg::sat_sub(t3_r, kti_pkg::twice(t2_r)), t_r);
        mul_b     = h_r;
        ret_nxt   = E_C6;
        state_nxt = S_WMUL;
      end
      E_C6: begin
        mul_start = 1'b1;
        mul_a     = mul_q;
        mul_b     = m0_r;
        ret_nxt   = E_C7;
        state_nxt = S_WMUL;
      end
      E_C7: begin
        acc_nxt   = kti_pkg::sat_add(acc_r, mul_q);
        mul_start = 1'b1;
        mul_a     = kti_pkg::sat_add(kti_pkg::sat_sub('0, kti_pkg::twice(t3_r)),
                                     kti_pkg::thrice(t2_r));
        mul_b     = y1_r;
        ret_nxt   = E_C8;
        state_nxt = S_WMUL;
      end
      E_C8: begin
        acc_nxt   = kti_pkg::sat_add(acc_r, mul_q);
        mul_start = 1'b1;
        mul_a     = kti_pkg::sat_sub(t3_r, t2_r);
        mul_b     = h_r;
        ret_nxt   = E_C9;
        state_nxt = S_WMUL;
      end
      E_C9: begin
        mul_start = 1'b1;
        mul_a     = mul_q;
        mul_b     = m1_r;
        ret_nxt   = E_C10;
        state_nxt = S_WMUL;
      end
      E_C10: begin
        res_nxt   = kti_pkg::sat_add(acc_r, mul_q);
        state_nxt = S_FINISH;
      end
      R_INIT: begin
        req.raddr = '0;
        k_nxt     = '0;
        state_nxt = R_RD0;
      end
      R_RD0: begin
        x0_nxt    = rd_time;
        y0_nxt    = rd_value;
        req.raddr = AW'(1);
        state_nxt = R_RD1;
      end
      // Secant of interval k; the previous interval shifts into the B pair.
      R_RD1: begin
        hb_nxt    = ha_r;
        sb_nxt    = sa_r;
        ha_nxt    = kti_pkg::sat_sub(rd_time, x0_r);
        x0_nxt    = rd_time;
        y0_nxt    = rd_value;
        div_start = 1'b1;
        div_a     = kti_pkg::sat_sub(rd_value, y0_r);
        div_b     = kti_pkg::sat_sub(rd_time, x0_r);
        ret_nxt   = R_S2;
        state_nxt = S_WDIV;
      end
      R_S2: begin
        sa_nxt = div_q;
        if (k_r == '0) begin
          h0_nxt = ha_r;
          s0_nxt = div_q;
        end
        if (k_r == AW'(1)) begin
          h1_nxt = ha_r;
          s1_nxt = div_q;
        end
        state_nxt = (k_r == '0) ? R_NEXT : R_I1;
      end
      R_I1: begin
        if (kti_pkg::sgn(sb_r) != kti_pkg::sgn(sa_r) || sb_r == '0) begin
          req.tan_we = 1'b1;
          req.waddr  = k_r;
          req.wtan   = '0;
          state_nxt  = R_NEXT;
        end else begin
          w1_nxt    = ww1;
          w2_nxt    = ww2;
          div_start = 1'b1;
          div_a     = ww1;
          div_b     = sb_r;
          ret_nxt   = R_I2;
          state_nxt = S_WDIV;
        end
      end
      R_I2: begin
        tmp_nxt   = div_q;
        div_start = 1'b1;
        div_a     = w2_r;
        div_b     = sa_r;
        ret_nxt   = R_I3;
        state_nxt = S_WDIV;
      end
      R_I3: begin
        if (den == '0) begin
          req.tan_we = 1'b1;
          req.waddr  = k_r;
          req.wtan   = (sa_r > 0) ? kti_pkg::VMAX : kti_pkg::VMIN;
          state_nxt  = R_NEXT;
        end else begin
          div_start = 1'b1;
          div_a     = kti_pkg::sat_add(w1_r, w2_r);
          div_b     = den;
          ret_nxt   = R_I4;
          state_nxt = S_WDIV;
        end
      end
      R_I4: begin
        req.tan_we = 1'b1;
        req.waddr  = k_r;
        req.wtan   = div_q;
        state_nxt  = R_NEXT;
      end
      R_NEXT: begin
        k_nxt = k_r + AW'(1);
        if ({1'b0, k_r} + CW'(2) < count_r) begin
          req.raddr = k_r + AW'(2);
          state_nxt = R_RD1;
        end else begin
          state_nxt = R_END;
        end
      end
      R_END: begin
        eb_nxt    = 1'b0;
        state_nxt = (count_r == CW'(2)) ? R_W0 : R_T1;
      end
      R_W0: begin
        req.tan_we = 1'b1;
        req.waddr  = '0;
        req.wtan   = s0_r;
        state_nxt  = R_W1;
      end
      R_W1: begin
        req.tan_we = 1'b1;
        req.waddr  = AW'(1);
        req.wtan   = s0_r;
        state_nxt  = R_DONE;
      end
      R_T1: begin
        mul_start = 1'b1;
        mul_a     = kti_pkg::sat_add(kti_pkg::twice(eh0), eh1);
        mul_b     = es0;
        ret_nxt   = R_T2;
        state_nxt = S_WMUL;
      end
      R_T2: begin
        tmp_nxt   = mul_q;
        mul_start = 1'b1;
        mul_a     = eh0;
        mul_b     = es1;
        ret_nxt   = R_T3;
        state_nxt = S_WMUL;
      end
      R_T3: begin
        div_start = 1'b1;
        div_a     = kti_pkg::sat_sub(tmp_r, mul_q);
        div_b     = kti_pkg::sat_add(eh0, eh1);
        ret_nxt   = R_T4;
        state_nxt = S_WDIV;
      end
      // Clamp the three-point end estimate to the shape of the data.
      R_T4: begin
        if (kti_pkg::sgn(div_q) != kti_pkg::sgn(es0)) begin
          dd = '0;
        end else if (kti_pkg::sgn(es0) != kti_pkg::sgn(es1) &&
                     kti_pkg::sat_abs(div_q) > kti_pkg::thrice(kti_pkg::sat_abs(es0))) begin
          dd = kti_pkg::thrice(es0);
        end
        req.tan_we = 1'b1;
        req.waddr  = eb_r ? last_idx : '0;
        req.wtan   = dd;
        eb_nxt     = 1'b1;
        state_nxt  = eb_r ? R_DONE : R_T1;
      end
      R_DONE: begin
        current_nxt = 1'b1;
        req.raddr   = lo_r;
        state_nxt   = E_RA;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= kti_pkg::MODE_STEP;
      count_r     <= '0;
      current_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      current_r   <= current_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;
    end
    ret_r <= ret_nxt;     eb_r <= eb_nxt;       lo_r <= lo_nxt;
    hi_r <= hi_nxt;       mid_r <= mid_nxt;     k_r <= k_nxt;
    stat_r <= stat_nxt;   last_t_r <= last_t_nxt; tau_r <= tau_nxt;
    res_r <= res_nxt;     x0_r <= x0_nxt;       y0_r <= y0_nxt;
    y1_r <= y1_nxt;       m0_r <= m0_nxt;       m1_r <= m1_nxt;
    h_r <= h_nxt;         t_r <= t_nxt;         t2_r <= t2_nxt;
    t3_r <= t3_nxt;       acc_r <= acc_nxt;     tmp_r <= tmp_nxt;
    w1_r <= w1_nxt;       w2_r <= w2_nxt;       ha_r <= ha_nxt;
    sa_r <= sa_nxt;       hb_r <= hb_nxt;       sb_r <= sb_nxt;
    h0_r <= h0_nxt;       s0_r <= s0_nxt;       h1_r <= h1_nxt;
    s1_r <= s1_nxt;
    out_res_r  <= out_res_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule
